// ===== rtl/core/rrle_pkg.sv =====
// Shared types and constants of the RGBE adaptive run-length scanline decoder.
package rrle_pkg;

  localparam int unsigned MAX_LINE_WIDTH_DEF = 32767;

  localparam int unsigned GEOM_W     = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned SPAN_W     = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PLANE_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_REVERSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_REVERSE    = 2'd3;

  typedef struct packed {
    logic [GEOM_W-1:0] line_width;
    logic [GEOM_W-1:0] line_count;
    logic              column_reverse;
    logic              row_reverse;
  } cfg_t;

  typedef struct packed {
    logic [GEOM_W-1:0]  row_index;
    logic [PLANE_W-1:0] plane;
    logic [GEOM_W-1:0]  start_column;
    logic [SPAN_W-1:0]  span_length;
    logic [BYTE_W-1:0]  pixel_value;
    logic               line_done;
    logic               image_done;
    logic               overrun;
  } res_t;

endpackage

// ===== rtl/core/rrle_cfg.sv =====
// Configuration register file of the scanline decoder.
module rrle_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rrle_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rrle_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output rrle_pkg::cfg_t                     cfg_o
);

  rrle_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        rrle_pkg::CFG_LINE_WIDTH:     cfg_d.line_width     = cfg_data_i;
        rrle_pkg::CFG_LINE_COUNT:     cfg_d.line_count     = cfg_data_i;
        rrle_pkg::CFG_COLUMN_REVERSE: cfg_d.column_reverse = cfg_data_i[0];
        rrle_pkg::CFG_ROW_REVERSE:    cfg_d.row_reverse    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width     <= rrle_pkg::GEOM_W'(1);
      cfg_q.line_count     <= rrle_pkg::GEOM_W'(1);
      cfg_q.column_reverse <= 1'b0;
      cfg_q.row_reverse    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/rrle_core.sv =====
// Decoder state and the combinational next-state and span logic.
module rrle_core #(
  parameter int unsigned MAX_LINE_WIDTH = rrle_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [rrle_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic                            image_start_i,
  input  rrle_pkg::cfg_t                  cfg_i,
  output logic                            res_vld_o,
  output rrle_pkg::res_t                  res_o
);

  localparam int unsigned WW   = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned PW   = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned CMPW = (WW > 8) ? WW : 8;
  localparam int unsigned GW   = rrle_pkg::GEOM_W;
  localparam int unsigned SW   = rrle_pkg::SPAN_W;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_CODE    = 2'd1;
  localparam logic [1:0] PH_RUNVAL  = 2'd2;
  localparam logic [1:0] PH_LITERAL = 2'd3;

  logic [1:0]    phase_q, phase_d, phase_0;
  logic [1:0]    hdr_q, hdr_d, hdr_0;
  logic [1:0]    plane_q, plane_d, plane_0;
  logic [PW-1:0] col_q, col_d, col_0;
  logic [GW-1:0] row_q, row_d, row_0;
  logic [7:0]    cl_q, cl_d, cl_0;
  logic [GW-1:0] rd_q, rd_d, rd_0;
  logic          drop_q, drop_d, drop_0;

  logic [WW-1:0] width_w;
  logic [GW-1:0] count_w;
  logic [PW-1:0] start_col_w;
  logic [GW-1:0] start_row_w;
  logic [PW-1:0] cur_col_w;
  logic [WW-1:0] room_w;
  logic          active_w;
  logic          cl_lt_room_w, cl_gt_room_w, room_one_w;
  logic [SW-1:0] span_len_w;
  logic          span_full_w, span_ldone_w, span_idone_w;
  logic [GW-1:0] rd_inc_w;
  logic [7:0]    cl_dec_w;
  logic          span_en, span_ovr;

  // Effective geometry: zero width or count acts as one, width is capped.
  always_comb begin
    if (cfg_i.line_width == '0) begin
      width_w = WW'(1);
    end else if (cfg_i.line_width > GW'(MAX_LINE_WIDTH)) begin
      width_w = WW'(MAX_LINE_WIDTH);
    end else begin
      width_w = WW'(cfg_i.line_width);
    end
  end

  assign count_w     = (cfg_i.line_count == '0) ? GW'(1) : cfg_i.line_count;
  assign start_col_w = cfg_i.column_reverse ? PW'(width_w - WW'(1)) : '0;
  assign start_row_w = cfg_i.row_reverse ? (count_w - GW'(1)) : '0;

  // A new image restarts the decoder before this byte is looked at.
  always_comb begin
    if (image_start_i) begin
      phase_0 = PH_HEADER;
      hdr_0   = '0;
      plane_0 = '0;
      col_0   = start_col_w;
      row_0   = start_row_w;
      cl_0    = '0;
      rd_0    = '0;
      drop_0  = 1'b0;
    end else begin
      phase_0 = phase_q;
      hdr_0   = hdr_q;
      plane_0 = plane_q;
      col_0   = col_q;
      row_0   = row_q;
      cl_0    = cl_q;
      rd_0    = rd_q;
      drop_0  = drop_q;
    end
  end

  assign cur_col_w = (WW'(col_0) < width_w) ? col_0 : PW'(width_w - WW'(1));
  assign room_w    = cfg_i.column_reverse ? (WW'(cur_col_w) + WW'(1))
                                          : (width_w - WW'(cur_col_w));
  assign active_w  = rd_0 < count_w;

  assign cl_lt_room_w = CMPW'(cl_0) < CMPW'(room_w);
  assign cl_gt_room_w = CMPW'(cl_0) > CMPW'(room_w);
  assign room_one_w   = room_w == WW'(1);
  assign cl_dec_w     = (cl_0 != '0) ? (cl_0 - 8'd1) : '0;

  // A run is clipped to the pixels left on the line; a literal is one pixel.
  assign span_len_w   = (phase_0 == PH_RUNVAL)
                        ? (cl_lt_room_w ? SW'(cl_0) : SW'(room_w)) : SW'(1);
  assign span_full_w  = CMPW'(span_len_w) >= CMPW'(room_w);
  assign span_ldone_w = span_full_w && (plane_0 == 2'd3);
  assign rd_inc_w     = rd_0 + GW'(1);
  assign span_idone_w = span_ldone_w && (rd_inc_w >= count_w);

  always_comb begin
    phase_d  = phase_0;
    hdr_d    = hdr_0;
    plane_d  = plane_0;
    col_d    = col_0;
    row_d    = row_0;
    cl_d     = cl_0;
    rd_d     = rd_0;
    drop_d   = drop_0;
    span_en  = 1'b0;
    span_ovr = 1'b0;
    if (active_w) begin
      unique case (phase_0)
        PH_HEADER: begin
          if (hdr_0 == 2'd3) begin
            hdr_d   = '0;
            phase_d = PH_CODE;
          end else begin
            hdr_d = hdr_0 + 2'd1;
          end
        end
        PH_CODE: begin
          if (data_byte_i > 8'd128) begin
            cl_d    = {1'b0, data_byte_i[6:0]};
            phase_d = PH_RUNVAL;
          end else if (data_byte_i != '0) begin
            cl_d    = data_byte_i;
            drop_d  = 1'b0;
            phase_d = PH_LITERAL;
          end
        end
        PH_RUNVAL: begin
          span_en  = 1'b1;
          span_ovr = cl_gt_room_w;
          cl_d     = '0;
          phase_d  = span_ldone_w ? PH_HEADER : PH_CODE;
        end
        PH_LITERAL: begin
          cl_d = cl_dec_w;
          if (drop_0) begin
            // Literals past the end of the line are swallowed.
            if (cl_dec_w == '0) begin
              drop_d  = 1'b0;
              phase_d = (plane_0 == 2'd0) ? PH_HEADER : PH_CODE;
            end
          end else begin
            span_en  = 1'b1;
            span_ovr = room_one_w && (cl_dec_w != '0);
            if (cl_dec_w == '0) begin
              phase_d = span_ldone_w ? PH_HEADER : PH_CODE;
            end else if (room_one_w) begin
              drop_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (span_en) begin
      if (!span_full_w) begin
        col_d = cfg_i.column_reverse
                ? PW'(CMPW'(cur_col_w) - CMPW'(span_len_w))
                : PW'(CMPW'(cur_col_w) + CMPW'(span_len_w));
      end else begin
        col_d = start_col_w;
        if (plane_0 == 2'd3) begin
          plane_d = '0;
          rd_d    = rd_inc_w;
          if (!span_idone_w) begin
            if (cfg_i.row_reverse) begin
              if (row_0 != '0) begin
                row_d = row_0 - GW'(1);
              end
            end else begin
              row_d = row_0 + GW'(1);
            end
          end
        end else begin
          plane_d = plane_0 + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hdr_q   <= '0;
      plane_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
      cl_q    <= '0;
      rd_q    <= '0;
      drop_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      plane_q <= plane_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cl_q    <= cl_d;
      rd_q    <= rd_d;
      drop_q  <= drop_d;
    end
  end

  assign res_vld_o          = span_en;
  assign res_o.row_index    = row_0;
  assign res_o.plane        = plane_0;
  assign res_o.start_column = GW'(cur_col_w);
  assign res_o.span_length  = span_len_w;
  assign res_o.pixel_value  = data_byte_i;
  assign res_o.line_done    = span_ldone_w;
  assign res_o.image_done   = span_idone_w;
  assign res_o.overrun      = span_ovr;

  a_line_done_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_vld_o && res_o.line_done |=> plane_q == 2'd0)
    else $error("plane did not wrap after a completed line");

  a_result_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |-> !image_start_i && (phase_q == PH_RUNVAL || phase_q == PH_LITERAL))
    else $error("span produced outside a run value or literal byte");

  a_header_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && active_w && !image_start_i && phase_q == PH_HEADER && hdr_q == 2'd3
    |=> phase_q == PH_CODE)
    else $error("header skip did not end after four bytes");

  a_run_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_vld_o && phase_q == PH_RUNVAL |=> cl_q == 8'd0)
    else $error("run count not cleared after the run value");

endmodule

// ===== rtl/core/rgbe_scanline_rle_decoder.sv =====
// Top level of the RGBE adaptive run-length scanline decoder.
// The decoder takes one encoded byte per cycle unless out_ready holds the
// result register full, and issues at most one span write per byte, so it
// has no stalls of its own; each byte is held first in the input register,
// and its result then in the result register, from which it is presented.
// The rate is set by the combinational state update between those two
// registers (column, plane and row advance, run clipping). Header bytes,
// code bytes and literals discarded past the end of a line produce no
// result. After reset the decoder is ready at once; image_start on a byte
// restarts it with the current geometry.
module rgbe_scanline_rle_decoder #(
  parameter int unsigned MAX_LINE_WIDTH = rrle_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rrle_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rrle_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rrle_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                              image_start_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rrle_pkg::GEOM_W-1:0]       row_index_o,
  output logic [rrle_pkg::PLANE_W-1:0]      plane_o,
  output logic [rrle_pkg::GEOM_W-1:0]       start_column_o,
  output logic [rrle_pkg::SPAN_W-1:0]       span_length_o,
  output logic [rrle_pkg::BYTE_W-1:0]       pixel_value_o,
  output logic                              line_done_o,
  output logic                              image_done_o,
  output logic                              overrun_o
);

  rrle_pkg::cfg_t cfg_w;
  rrle_pkg::res_t res_w;
  rrle_pkg::res_t res_q;
  logic           res_vld_w;

  logic                        in_vld_q;
  logic [rrle_pkg::BYTE_W-1:0] byte_q;
  logic                        start_q;
  logic                        out_vld_q;
  logic                        step_w;

  // The held item moves on when the result register is free or being emptied.
  assign step_w     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step_w;

  rrle_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg_w)
  );

  rrle_core #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step_w),
    .data_byte_i   (byte_q),
    .image_start_i (start_q),
    .cfg_i         (cfg_w),
    .res_vld_o     (res_vld_w),
    .res_o         (res_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (step_w && res_vld_w) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= data_byte_i;
      start_q <= image_start_i;
    end
    if (step_w && res_vld_w) begin
      res_q <= res_w;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign row_index_o    = res_q.row_index;
  assign plane_o        = res_q.plane;
  assign start_column_o = res_q.start_column;
  assign span_length_o  = res_q.span_length;
  assign pixel_value_o  = res_q.pixel_value;
  assign line_done_o    = res_q.line_done;
  assign image_done_o   = res_q.image_done;
  assign overrun_o      = res_q.overrun;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the RGBE run-length scanline decoder.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {DS_HEADER, DS_CODE, DS_RUN_VALUE, DS_LITERAL} dec_phase_e;

  typedef struct packed {
    logic [rrle_pkg::BYTE_W-1:0] value;
    logic                        first;
  } enc_byte_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [rrle_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [rrle_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [rrle_pkg::BYTE_W-1:0]     data_byte_i = '0;
  logic                            image_start_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [rrle_pkg::GEOM_W-1:0]     row_index_o;
  logic [rrle_pkg::PLANE_W-1:0]    plane_o;
  logic [rrle_pkg::GEOM_W-1:0]     start_column_o;
  logic [rrle_pkg::SPAN_W-1:0]     span_length_o;
  logic [rrle_pkg::BYTE_W-1:0]     pixel_value_o;
  logic                            line_done_o;
  logic                            image_done_o;
  logic                            overrun_o;

  rgbe_scanline_rle_decoder u_dut (.*);

  enc_byte_t      byte_q[$];
  rrle_pkg::res_t spans_expected[$];
  int unsigned    bytes_queued = 0;
  int unsigned    mismatches = 0;
  int unsigned    cycle_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    hold_req = 0;
  int unsigned    hold_ack = 0;
  int unsigned    hold_left = 0;
  logic           in_taken = 1'b0;

  // Decoder state as the scoreboard sees it.
  rrle_pkg::cfg_t geom;
  dec_phase_e     dphase;
  int unsigned    hdr_seen, plane_no, col_at, row_at, count_rem, lines_done;
  bit             dropping;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned width_eff();
    int unsigned w;
    w = geom.line_width;
    if (w < 1) w = 1;
    if (w > rrle_pkg::MAX_LINE_WIDTH_DEF) w = rrle_pkg::MAX_LINE_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned count_eff();
    return (geom.line_count < 1) ? 1 : geom.line_count;
  endfunction

  function automatic int unsigned first_col();
    return geom.column_reverse ? width_eff() - 1 : 0;
  endfunction

  function automatic int unsigned first_row();
    return geom.row_reverse ? count_eff() - 1 : 0;
  endfunction

  // A column left beyond a narrowed line counts as its last column.
  function automatic int unsigned col_now();
    return (col_at < width_eff()) ? col_at : width_eff() - 1;
  endfunction

  function automatic int unsigned cols_left();
    return geom.column_reverse ? col_now() + 1 : width_eff() - col_now();
  endfunction

  function automatic void restart_image();
    dphase = DS_HEADER;
    hdr_seen = 0;
    plane_no = 0;
    col_at = first_col();
    row_at = first_row();
    count_rem = 0;
    lines_done = 0;
    dropping = 1'b0;
  endfunction

  // Fills in one span write and advances the position; true when the line is complete.
  function automatic bit emit_span(int unsigned len, logic [rrle_pkg::BYTE_W-1:0] val,
                                   bit ovr, output rrle_pkg::res_t sp);
    int unsigned col;
    bit full, ldone, idone;
    col = col_now();
    full = len >= cols_left();
    ldone = full && plane_no == 3;
    idone = 1'b0;
    sp.row_index = rrle_pkg::GEOM_W'(row_at);
    sp.plane = rrle_pkg::PLANE_W'(plane_no);
    sp.start_column = rrle_pkg::GEOM_W'(col);
    sp.span_length = rrle_pkg::SPAN_W'(len);
    sp.pixel_value = val;
    sp.line_done = ldone;
    sp.overrun = ovr;
    if (!full) begin
      col_at = geom.column_reverse ? col - len : col + len;
    end else begin
      col_at = first_col();
      if (plane_no == 3) begin
        plane_no = 0;
        lines_done = (lines_done + 1) & 'h7fff;
        idone = lines_done >= count_eff();
        if (!idone) begin
          if (geom.row_reverse) begin
            if (row_at > 0) row_at--;
          end else begin
            row_at = (row_at + 1) & 'h7fff;
          end
        end
      end else begin
        plane_no++;
      end
    end
    sp.image_done = idone;
    return ldone;
  endfunction

  function automatic bit decode_byte(logic [rrle_pkg::BYTE_W-1:0] b, logic start,
                                     output rrle_pkg::res_t sp);
    int unsigned avail, len;
    bit full, ldone, got;
    got = 1'b0;
    sp = '0;
    if (start) restart_image();
    if (lines_done < count_eff()) begin
      case (dphase)
        DS_HEADER: begin
          if (hdr_seen >= 3) begin
            hdr_seen = 0;
            dphase = DS_CODE;
          end else begin
            hdr_seen++;
          end
        end
        DS_CODE: begin
          if (b > 128) begin
            count_rem = b & 127;
            dphase = DS_RUN_VALUE;
          end else if (b != 0) begin
            count_rem = b;
            dropping = 1'b0;
            dphase = DS_LITERAL;
          end
        end
        DS_RUN_VALUE: begin
          avail = cols_left();
          len = (count_rem < avail) ? count_rem : avail;
          ldone = emit_span(len, b, count_rem > avail, sp);
          count_rem = 0;
          dphase = ldone ? DS_HEADER : DS_CODE;
          got = 1'b1;
        end
        default: begin
          if (count_rem > 0) count_rem--;
          if (dropping) begin
            // Literals beyond the end of the line are swallowed.
            if (count_rem == 0) begin
              dropping = 1'b0;
              dphase = (plane_no == 0) ? DS_HEADER : DS_CODE;
            end
          end else begin
            full = cols_left() == 1;
            ldone = emit_span(1, b, full && count_rem > 0, sp);
            if (count_rem == 0) dphase = ldone ? DS_HEADER : DS_CODE;
            else if (full) dropping = 1'b1;
            got = 1'b1;
          end
        end
      endcase
    end
    return got;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Input driver: one item at a time from byte_q, with random gaps.
  always @(negedge clk_i) begin : drive_bytes
    enc_byte_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_q.pop_front();
        in_valid_i <= 1'b1;
        data_byte_i <= nxt.value;
        image_start_i <= nxt.first;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure, including the long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch_spans
    rrle_pkg::res_t predicted, want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (decode_byte(data_byte_i, image_start_i, predicted)) begin
        spans_expected.push_back(predicted);
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (spans_expected.size() == 0) begin
        report_mismatch("span write with none expected");
      end else begin
        want = spans_expected.pop_front();
        check_field("row_index", row_index_o, want.row_index);
        check_field("plane", plane_o, want.plane);
        check_field("start_column", start_column_o, want.start_column);
        check_field("span_length", span_length_o, want.span_length);
        check_field("pixel_value", pixel_value_o, want.pixel_value);
        check_field("line_done", line_done_o, want.line_done);
        check_field("image_done", image_done_o, want.image_done);
        check_field("overrun", overrun_o, want.overrun);
      end
    end
  end

  function automatic void put(logic [rrle_pkg::BYTE_W-1:0] v, logic s);
    byte_q.push_back('{value: v, first: s});
    bytes_queued++;
  endfunction

  task automatic write_reg(logic [rrle_pkg::CFG_IDX_W-1:0] idx,
                           logic [rrle_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      rrle_pkg::CFG_LINE_WIDTH:     geom.line_width = val;
      rrle_pkg::CFG_LINE_COUNT:     geom.line_count = val;
      rrle_pkg::CFG_COLUMN_REVERSE: geom.column_reverse = val[0];
      rrle_pkg::CFG_ROW_REVERSE:    geom.row_reverse = val[0];
      default: ;
    endcase
  endtask

  // The one-bit registers get random upper bits, which must be ignored.
  task automatic set_geometry(int unsigned w, int unsigned c, bit cr, bit rr);
    write_reg(rrle_pkg::CFG_LINE_WIDTH, rrle_pkg::GEOM_W'(w));
    write_reg(rrle_pkg::CFG_LINE_COUNT, rrle_pkg::GEOM_W'(c));
    write_reg(rrle_pkg::CFG_COLUMN_REVERSE, {14'($urandom), cr});
    write_reg(rrle_pkg::CFG_ROW_REVERSE, {14'($urandom), rr});
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (byte_q.size() != 0 || in_valid_i || spans_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Well-formed planes with random content; now and then a run or a literal
  // string overshoots the line, and now and then an empty code appears.
  task automatic push_planes(int unsigned w, int unsigned first_plane);
    int unsigned p, left, n;
    for (p = first_plane; p < 4; p++) begin
      left = w;
      while (left != 0) begin
        case ($urandom_range(99) / 50)
          0: begin
            if ($urandom_range(99) < 8) begin
              put(8'h00, 1'b0);
            end else begin
              n = ($urandom_range(9) == 0) ? $urandom_range(127, 1)
                                           : $urandom_range((left < 127) ? left : 127, 1);
              put(8'(128 + n), 1'b0);
              put(8'($urandom), 1'b0);
              left -= (n < left) ? n : left;
            end
          end
          default: begin
            n = ($urandom_range(14) == 0) ? $urandom_range(128, 1)
                                          : $urandom_range((left < 16) ? left : 16, 1);
            put(8'(n), 1'b0);
            repeat (n) put(8'($urandom), 1'b0);
            left -= (n < left) ? n : left;
          end
        endcase
      end
    end
  endtask

  task automatic push_line(int unsigned w, logic start);
    put(8'($urandom), start);
    repeat (3) put(8'($urandom), 1'b0);
    push_planes(w, 0);
  endtask

  task automatic push_image(int unsigned w, int unsigned c);
    int unsigned l;
    for (l = 0; l < c; l++) push_line(w, l == 0);
  endtask

  // Garbage, sometimes with restarts in odd places.
  task automatic push_noise();
    int unsigned i, n;
    n = $urandom_range(12, 2);
    for (i = 0; i < n; i++) begin
      put(8'($urandom), (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(15) == 0));
    end
  endtask

  initial begin
    int unsigned mode, k, w, c, target;
    geom = '{line_width: 15'd1, line_count: 15'd1, column_reverse: 1'b0, row_reverse: 1'b1};
    restart_image();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Width and count of zero behave as one; a single-pixel image.
    set_geometry(0, 0, 1, 1);
    put(8'hA5, 1'b1); put(8'h5A, 1'b0); put(8'hFF, 1'b0); put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'h83, 1'b0); put(8'hFF, 1'b0);
    put(8'h02, 1'b0); put(8'h80, 1'b0); put(8'h7F, 1'b0);
    put(8'h81, 1'b0); put(8'h00, 1'b0);
    put(8'h01, 1'b0); put(8'hAA, 1'b0);
    put(8'h55, 1'b0);
    wait_drained();

    set_geometry(2, 2, 0, 0);
    put(8'h01, 1'b1); put(8'hFE, 1'b0); put(8'h80, 1'b0); put(8'h7F, 1'b0);
    put(8'hFF, 1'b0); put(8'h12, 1'b0);
    put(8'h02, 1'b0); put(8'h01, 1'b0); put(8'h02, 1'b0);
    put(8'h82, 1'b0); put(8'h33, 1'b0);
    put(8'h82, 1'b0); put(8'hEE, 1'b0);
    wait_drained();

    // Narrow the line while the decoder stands past the new last column.
    set_geometry(20, 3, 0, 1);
    put(8'h3C, 1'b1);
    repeat (3) put(8'($urandom), 1'b0);
    put(8'h8F, 1'b0); put(8'h3C, 1'b0);
    wait_drained();
    set_geometry(5, 3, 0, 1);
    put(8'h83, 1'b0); put(8'hC3, 1'b0);
    push_planes(5, 1);
    push_line(5, 1'b0);
    wait_drained();

    // Largest geometry, then a change of direction in mid-line.
    set_geometry(32767, 32767, 1, 1);
    put(8'($urandom), 1'b1);
    repeat (3) put(8'($urandom), 1'b0);
    put(8'hFF, 1'b0); put(8'($urandom), 1'b0);
    put(8'h80, 1'b0);
    repeat (128) put(8'($urandom), 1'b0);
    wait_drained();
    set_geometry(32767, 32767, 0, 0);
    put(8'hFF, 1'b0); put(8'($urandom), 1'b0);
    put(8'h81, 1'b0); put(8'($urandom), 1'b0);
    wait_drained();

    // Long output hold-off while the input keeps coming.
    set_geometry(20, 2, 1, 0);
    push_image(20, 2);
    hold_req++;
    wait_drained();

    for (mode = 0; mode < 4; mode++) begin
      send_idle_pct = (mode == 1) ? 83 : (mode == 3) ? 34 : 0;
      recv_stall_pct = (mode == 2) ? 83 : (mode == 3) ? 34 : 0;
      for (k = 0; k < 2; k++) begin
        w = ($urandom_range(7) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
        c = $urandom_range(2, 1);
        set_geometry(w, c, 1'($urandom_range(1)), 1'($urandom_range(1)));
        target = bytes_queued + 60;
        while (bytes_queued < target) begin
          if ($urandom_range(9) == 0) push_noise();
          else push_image(w, c);
        end
        wait_drained();
      end
    end

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
